>>> design/ima_adpcm_block_decoder_macros.svh
// assertion helpers for the decoder back end
`ifndef IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_BLOCK_DECODER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define IMADEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define IMADEC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/imadec_pkg.sv
`timescale 1ns / 1ps
package imadec_pkg;

  // block geometry and limits
  localparam logic [6:0] MONO_BYTES   = 7'd36;
  localparam logic [6:0] STEREO_BYTES = 7'd72;
  localparam logic [6:0] INDEX_MAX    = 7'd88;

  // work items passed from the byte front end to the decode engine
  typedef enum logic [2:0] {
    CMD_SET_PRED,
    CMD_SET_INDEX,
    CMD_EMIT_HDR,
    CMD_DATA_MONO,
    CMD_DATA_STEREO
  } cmd_kind_t;

  // val: predictor, step index, mono byte, or {right byte, left byte}
  typedef struct packed {
    cmd_kind_t   kind;
    logic        chan;
    logic        blk_end;
    logic [15:0] val;
  } cmd_t;

  // standard ima step size table
  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;
      7'd3: s = 15'd10;      7'd4: s = 15'd11;      7'd5: s = 15'd12;
      7'd6: s = 15'd13;      7'd7: s = 15'd14;      7'd8: s = 15'd16;
      7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
      7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
      7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
      7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
      7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
      7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
      7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
      7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
      7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
      7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
      7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
      7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
      7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
      7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
      7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

>>> design/imadec_front.sv
`timescale 1ns / 1ps
module imadec_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] byte_value
  input  logic               q_full,
  output logic               push,
  output imadec_pkg::cmd_t   push_cmd
);

  // header byte offsets within one channel header
  localparam logic [1:0] HDR_PRED_LO = 2'd0;
  localparam logic [1:0] HDR_PRED_HI = 2'd1;
  localparam logic [1:0] HDR_INDEX   = 2'd2;
  localparam logic [1:0] HDR_PAD     = 2'd3;

  logic       stereo_r, stereo_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [7:0] hdr_low_r;
  logic [7:0] lbuf_r [4];

  logic       fire;
  logic [6:0] size, cur, cur_inc;
  logic       is_hdr, need_push, hdr_low_we, lbuf_we;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  // block position, restarting at zero if a mode change leaves it past the block end
  always_comb begin
    size    = stereo_r ? imadec_pkg::STEREO_BYTES : imadec_pkg::MONO_BYTES;
    cur     = (pos_r >= size) ? 7'd0 : pos_r;
    cur_inc = cur + 7'd1;
    pos_nxt = fire ? ((cur_inc >= size) ? 7'd0 : cur_inc) : pos_r;
    stereo_nxt = cfg_wr_en ? cfg_wr_data : stereo_r;
  end

  // classify the byte and build the work item
  always_comb begin
    is_hdr     = stereo_r ? (cur < 7'd8) : (cur < 7'd4);
    need_push  = 1'b0;
    hdr_low_we = 1'b0;
    lbuf_we    = 1'b0;
    push_cmd.kind    = imadec_pkg::CMD_EMIT_HDR;
    push_cmd.chan    = stereo_r & cur[2];
    push_cmd.blk_end = 1'b0;
    push_cmd.val     = 16'h0000;
    if (is_hdr) begin
      unique case (cur[1:0])
        HDR_PRED_LO: begin
          hdr_low_we = 1'b1;
        end
        HDR_PRED_HI: begin
          need_push     = 1'b1;
          push_cmd.kind = imadec_pkg::CMD_SET_PRED;
          push_cmd.val  = {in_tdata, hdr_low_r};
        end
        HDR_INDEX: begin
          need_push     = 1'b1;
          push_cmd.kind = imadec_pkg::CMD_SET_INDEX;
          push_cmd.val  = (in_tdata > {1'b0, imadec_pkg::INDEX_MAX}) ?
                          {9'd0, imadec_pkg::INDEX_MAX} : {8'd0, in_tdata};
        end
        HDR_PAD: begin
          need_push     = 1'b1;
          push_cmd.kind = imadec_pkg::CMD_EMIT_HDR;
        end
        default: ;
      endcase
    end else if (!stereo_r) begin
      need_push        = 1'b1;
      push_cmd.kind    = imadec_pkg::CMD_DATA_MONO;
      push_cmd.val     = {8'd0, in_tdata};
      push_cmd.blk_end = (cur == imadec_pkg::MONO_BYTES - 7'd1);
    end else if (!cur[2]) begin
      lbuf_we = 1'b1;
    end else begin
      need_push        = 1'b1;
      push_cmd.kind    = imadec_pkg::CMD_DATA_STEREO;
      push_cmd.val     = {in_tdata, lbuf_r[cur[1:0]]};
      push_cmd.blk_end = (cur == imadec_pkg::STEREO_BYTES - 7'd1);
    end
    push = fire && need_push;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
      pos_r    <= 7'd0;
    end else begin
      stereo_r <= stereo_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // predictor low byte and left chunk bytes
  always_ff @(posedge clk) begin
    if (fire && hdr_low_we) begin
      hdr_low_r <= in_tdata;
    end
    if (fire && lbuf_we) begin
      lbuf_r[cur[1:0]] <= in_tdata;
    end
  end

endmodule

>>> design/imadec_fifo.sv
`timescale 1ns / 1ps
module imadec_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  imadec_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output imadec_pkg::cmd_t q_cmd
);

  imadec_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/imadec_back.sv
`timescale 1ns / 1ps
`include "ima_adpcm_block_decoder_macros.svh"
module imadec_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  imadec_pkg::cmd_t q_cmd,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // [15:0] sample
  output logic [1:0]       out_tuser,  // [0] channel, [1] block_end
  output logic             out_tlast
);

  logic signed [15:0] pred_r [2];
  logic signed [15:0] pred_nxt [2];
  logic [6:0]         idx_r [2];
  logic [6:0]         idx_nxt [2];
  logic [1:0]         step_r, step_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [15:0]        osample_r, osample_nxt;
  logic               ochan_r, ochan_nxt;
  logic               oend_r, oend_nxt;
  logic               olast_r, olast_nxt;

  logic               go, is_mono, is_stereo, final_step, ch;
  logic [7:0]         cur_byte;
  logic [3:0]         nib;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] psum;
  logic signed [15:0] psat;
  logic signed [7:0]  ishift, isum;
  logic [6:0]         iclamp;

  assign is_mono   = (q_cmd.kind == imadec_pkg::CMD_DATA_MONO);
  assign is_stereo = (q_cmd.kind == imadec_pkg::CMD_DATA_STEREO);
  assign go        = q_valid && (!ovalid_r || out_tready);

  // select channel and nibble for this sub-step
  always_comb begin
    ch         = is_stereo ? step_r[0] : (is_mono ? 1'b0 : q_cmd.chan);
    cur_byte   = (is_stereo && step_r[0]) ? q_cmd.val[15:8] : q_cmd.val[7:0];
    nib        = (is_stereo ? step_r[1] : step_r[0]) ? cur_byte[7:4] : cur_byte[3:0];
    final_step = is_stereo ? (step_r == 2'd3) : (is_mono ? (step_r == 2'd1) : 1'b1);
  end

  // nibble decode: step lookup, difference, saturating add
  always_comb begin
    step = imadec_pkg::step_lookup(idx_r[ch]);
    diff = {5'd0, step[14:3]}
         + (nib[0] ? {4'd0, step[14:2]} : 17'd0)
         + (nib[1] ? {3'd0, step[14:1]} : 17'd0)
         + (nib[2] ? {2'd0, step} : 17'd0);
    psum = nib[3] ? ({{2{pred_r[ch][15]}}, pred_r[ch]} - $signed({1'b0, diff}))
                  : ({{2{pred_r[ch][15]}}, pred_r[ch]} + $signed({1'b0, diff}));
    if (psum > 18'sd32767) begin
      psat = 16'sh7FFF;
    end else if (psum < -18'sd32768) begin
      psat = 16'sh8000;
    end else begin
      psat = psum[15:0];
    end
  end

  // step index adaptation with clamp to 0..88
  always_comb begin
    ishift = nib[2] ? $signed({5'd0, nib[1:0], 1'b0} + 8'd2) : -8'sd1;
    isum   = $signed({1'b0, idx_r[ch]}) + ishift;
    if (isum < 8'sd0) begin
      iclamp = 7'd0;
    end else if (isum > $signed({1'b0, imadec_pkg::INDEX_MAX})) begin
      iclamp = imadec_pkg::INDEX_MAX;
    end else begin
      iclamp = isum[6:0];
    end
  end

  // execute the item at the queue head
  always_comb begin
    pred_nxt    = pred_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    osample_nxt = osample_r;
    ochan_nxt   = ochan_r;
    oend_nxt    = oend_r;
    olast_nxt   = olast_r;
    q_pop       = go && final_step;
    if (go) begin
      step_nxt = final_step ? 2'd0 : step_r + 2'd1;
      unique case (q_cmd.kind)
        imadec_pkg::CMD_SET_PRED: begin
          pred_nxt[ch] = q_cmd.val;
        end
        imadec_pkg::CMD_SET_INDEX: begin
          idx_nxt[ch] = q_cmd.val[6:0];
        end
        imadec_pkg::CMD_EMIT_HDR: begin
          ovalid_nxt  = 1'b1;
          osample_nxt = pred_r[ch];
          ochan_nxt   = ch;
          oend_nxt    = 1'b0;
          olast_nxt   = 1'b1;
        end
        imadec_pkg::CMD_DATA_MONO, imadec_pkg::CMD_DATA_STEREO: begin
          pred_nxt[ch] = psat;
          idx_nxt[ch]  = iclamp;
          ovalid_nxt   = 1'b1;
          osample_nxt  = psat;
          ochan_nxt    = ch;
          oend_nxt     = final_step && q_cmd.blk_end;
          olast_nxt    = final_step;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r[0] <= 16'sd0;
      pred_r[1] <= 16'sd0;
      idx_r[0]  <= 7'd0;
      idx_r[1]  <= 7'd0;
      step_r    <= 2'd0;
      ovalid_r  <= 1'b0;
    end else begin
      pred_r   <= pred_nxt;
      idx_r    <= idx_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    osample_r <= osample_nxt;
    ochan_r   <= ochan_nxt;
    oend_r    <= oend_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = osample_r;
  assign out_tuser  = {oend_r, ochan_r};
  assign out_tlast  = olast_r;

  `IMADEC_ASSERT(a_step_idle, (!q_valid |-> step_r == 2'd0), "sub-step left set with queue empty")
  `IMADEC_ASSERT(a_step_data, (step_r != 2'd0 |-> (is_mono || is_stereo)), "sub-step on non-data item")
  `IMADEC_NEVER(a_idx_range, (idx_r[0] > imadec_pkg::INDEX_MAX || idx_r[1] > imadec_pkg::INDEX_MAX), "step index above 88")
  `IMADEC_ASSERT(a_end_last, (ovalid_r && oend_r |-> olast_r), "block end without last")

endmodule

>>> design/ima_adpcm_block_decoder.sv
`timescale 1ns / 1ps
// path: an accepted byte passes the work item queue, then the result reg, before its first sample at out_tvalid
// throughput: one byte per cycle into the front end unless the queue is full; the engine emits one
//   sample per cycle unless the output stalls: two per mono byte, four per stereo right byte
// header bytes but the predictor low byte make one work item, stereo left bytes none; a 2-entry queue absorbs bursts
// reset: rst_n synchronous active low; clears mode (mono), block position, predictors,
//   step indexes, queue and output valid
module ima_adpcm_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // stereo_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] byte_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [15:0] sample
  output logic [1:0]  out_tuser,    // [0] channel, [1] block_end
  output logic        out_tlast
);

  logic             push, q_full, q_valid, q_pop;
  imadec_pkg::cmd_t push_cmd, q_cmd;

  // byte tracking and classification
  imadec_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // work item queue
  imadec_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // nibble decode and result register
  imadec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
